>>> design/rmgr_pkg.sv
// ----------------------------------------------------------------------------
// rmgr_pkg
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rmgr_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;
   localparam int DEG_W      = 3;
   localparam int SLOT_W     = 3;
   localparam int CNT_W      = 7;
   localparam int INDEX_W    = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_ORDER     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VARIABLE_COUNT = 1'b1;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] CODE_ORDER_RST     = 3'd1;
   localparam logic [CSR_DATA_W-1:0] VARIABLE_COUNT_RST = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic start;      // request taken, apply restart
      logic prep;       // evaluate last flag, capture index/degree, seed row
      logic row_step;   // AND one variable row into the accumulator
      logic scan_init;  // point the scan at the highest slot
      logic scan_step;  // one step of the next-combination search
      logic load_out;   // move the finished row into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic row_done;   // all slots of this degree folded in
      logic scan_done;  // the scan step issued now completes the update
   } status_type;

endpackage

>>> design/rmgr_ctrl.sv
// ----------------------------------------------------------------------------
// rmgr_ctrl
// Sequencer: takes one request, walks the datapath through row build and
// combination update, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rmgr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rmgr_pkg::status_type st,
   output rmgr_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_ROW  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_ROW;
         end
         S_ROW: begin
            if (st.row_done) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               cmd.row_step = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // output register free or emptying this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/rmgr_datapath.sv
// ----------------------------------------------------------------------------
// rmgr_datapath
// Configuration registers, enumeration state (degree, slots, row counter),
// row accumulator and output payload register.
// ----------------------------------------------------------------------------
module rmgr_datapath #(
   parameter int MAX_VARS  = 6,
   parameter int ROW_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rmgr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rmgr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_restart,
   input  rmgr_pkg::cmd_type                    cmd,
   output rmgr_pkg::status_type                 st,
   output logic [ROW_WIDTH-1:0]                 rsp_row_bits,
   output logic [rmgr_pkg::INDEX_W-1:0]         rsp_row_index,
   output logic [rmgr_pkg::DEG_W-1:0]           rsp_row_degree,
   output logic                                 rsp_last_row
);

   localparam int SLOT_IW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int PW      = $clog2(MAX_VARS + 1);

   // config
   logic [rmgr_pkg::CSR_DATA_W-1:0] code_order_ff, variable_count_ff;

   // enumeration state
   logic [rmgr_pkg::DEG_W-1:0]  degree_ff, degree_in;
   logic [rmgr_pkg::SLOT_W-1:0] slots_ff [MAX_VARS];
   logic [rmgr_pkg::SLOT_W-1:0] slots_in [MAX_VARS];
   logic [rmgr_pkg::CNT_W-1:0]  counter_ff, counter_in;
   logic                        finished_ff, finished_in;

   // per-request working registers
   logic [PW-1:0]               ptr_ff, ptr_in;
   logic [ROW_WIDTH-1:0]        acc_ff, acc_in;
   logic                        last_ff;
   logic [rmgr_pkg::INDEX_W-1:0] res_index_ff;
   logic [rmgr_pkg::DEG_W-1:0]  res_degree_ff;

   // output payload
   logic [ROW_WIDTH-1:0]        out_bits_ff;
   logic [rmgr_pkg::INDEX_W-1:0] out_index_ff;
   logic [rmgr_pkg::DEG_W-1:0]  out_degree_ff;
   logic                        out_last_ff;

   logic [2:0]                  m_eff, r_eff;
   logic [rmgr_pkg::SLOT_W-1:0] slot_p;
   logic signed [4:0]           lim_first, lim_p;
   logic                        hit, last_now;
   logic [ROW_WIDTH-1:0]        col_mask, vrow;
   logic [rmgr_pkg::CNT_W-1:0]  counter_inc;
   logic [rmgr_pkg::DEG_W-1:0]  degree_up;

   // variable row j over m variables: bit k = bit (m-j) of k, zero if j is
   // not one of 1..m
   function automatic logic [ROW_WIDTH-1:0] var_row(input logic [2:0] m_v,
                                                    input logic [2:0] j);
      logic [ROW_WIDTH-1:0] row;
      logic [2:0]           sh;
      logic [5:0]           kk;
      logic [5:0]           shifted;
      logic                 ok;
      ok = (j != 3'd0) && (j <= m_v);
      sh = m_v - j;
      for (int k = 0; k < ROW_WIDTH; k++) begin
         kk      = 6'(k);
         shifted = kk >> sh;
         row[k]  = ok & shifted[0];
      end
      return row;
   endfunction

   assign m_eff = (variable_count_ff > 3'(MAX_VARS)) ? 3'(MAX_VARS) : variable_count_ff;
   assign r_eff = (code_order_ff > m_eff) ? m_eff : code_order_ff;

   always_comb begin
      logic [6:0] cols;
      cols = 7'd1 << m_eff;
      for (int k = 0; k < ROW_WIDTH; k++) begin
         col_mask[k] = (7'(k) < cols);
      end
   end

   assign slot_p    = slots_ff[ptr_ff[SLOT_IW-1:0]];
   assign vrow      = var_row(m_eff, slot_p);
   assign lim_first = $signed({2'b00, m_eff}) - $signed({2'b00, degree_ff}) + 5'sd1;
   assign lim_p     = lim_first + $signed(5'(ptr_ff));
   assign hit       = $signed({2'b00, slot_p}) < lim_p;
   assign last_now  = finished_ff ||
                      ((degree_ff >= r_eff) &&
                       ((degree_ff == '0) ||
                        ($signed({2'b00, slots_ff[0]}) >= lim_first)));

   assign counter_inc = (counter_ff == '1) ? counter_ff : counter_ff + 1'b1;
   assign degree_up   = (degree_ff == 3'(MAX_VARS)) ? degree_ff : degree_ff + 1'b1;

   assign st.row_done  = (rmgr_pkg::DEG_W'(ptr_ff) == degree_ff);
   assign st.scan_done = last_ff || (degree_ff == '0) || hit || (ptr_ff == '0);

   // next enumeration state
   always_comb begin
      degree_in   = degree_ff;
      slots_in    = slots_ff;
      counter_in  = counter_ff;
      finished_in = finished_ff;
      ptr_in      = ptr_ff;
      acc_in      = acc_ff;
      if (cmd.start && req_restart) begin
         degree_in   = '0;
         counter_in  = '0;
         finished_in = 1'b0;
      end
      if (cmd.prep) begin
         ptr_in = '0;
         acc_in = col_mask;
      end
      if (cmd.row_step) begin
         acc_in = acc_ff & vrow;
         ptr_in = ptr_ff + 1'b1;
      end
      if (cmd.scan_init) begin
         ptr_in = PW'(degree_ff - 1'b1);
      end
      if (cmd.scan_step) begin
         if (last_ff) begin
            finished_in = 1'b1;
         end else if (degree_ff == '0) begin
            degree_in   = 3'd1;
            slots_in[0] = 3'd1;
            counter_in  = counter_inc;
         end else if (hit) begin
            // bump this slot, pack the higher ones right after it
            for (int q = 0; q < MAX_VARS; q++) begin
               if (rmgr_pkg::SLOT_W'(q) == rmgr_pkg::SLOT_W'(ptr_ff)) begin
                  slots_in[q] = slot_p + 1'b1;
               end else if ((rmgr_pkg::SLOT_W'(q) > rmgr_pkg::SLOT_W'(ptr_ff)) &&
                            (rmgr_pkg::DEG_W'(q) < degree_ff)) begin
                  slots_in[q] = slot_p + 1'b1 + rmgr_pkg::SLOT_W'(q)
                                - rmgr_pkg::SLOT_W'(ptr_ff);
               end
            end
            counter_in = counter_inc;
         end else if (ptr_ff == '0) begin
            // combinations of this degree exhausted
            degree_in = degree_up;
            for (int q = 0; q < MAX_VARS; q++) begin
               slots_in[q] = rmgr_pkg::SLOT_W'(q + 1);
            end
            counter_in = counter_inc;
         end else begin
            ptr_in = ptr_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_order_ff     <= rmgr_pkg::CODE_ORDER_RST;
         variable_count_ff <= rmgr_pkg::VARIABLE_COUNT_RST;
         degree_ff         <= '0;
         counter_ff        <= '0;
         finished_ff       <= 1'b0;
         for (int q = 0; q < MAX_VARS; q++) begin
            slots_ff[q] <= '0;
         end
      end else begin
         if (csr_we && (csr_index == rmgr_pkg::CSR_CODE_ORDER)) begin
            code_order_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == rmgr_pkg::CSR_VARIABLE_COUNT)) begin
            variable_count_ff <= csr_wdata;
         end
         degree_ff   <= degree_in;
         counter_ff  <= counter_in;
         finished_ff <= finished_in;
         slots_ff    <= slots_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      acc_ff <= acc_in;
      if (cmd.prep) begin
         last_ff       <= last_now;
         res_index_ff  <= counter_ff[rmgr_pkg::INDEX_W-1:0];
         res_degree_ff <= degree_ff;
      end
      if (cmd.load_out) begin
         out_bits_ff   <= acc_ff;
         out_index_ff  <= res_index_ff;
         out_degree_ff <= res_degree_ff;
         out_last_ff   <= last_ff;
      end
   end

   assign rsp_row_bits   = out_bits_ff;
   assign rsp_row_index  = out_index_ff;
   assign rsp_row_degree = out_degree_ff;
   assign rsp_last_row   = out_last_ff;

endmodule

>>> design/reed_muller_generator_rows.sv
// ----------------------------------------------------------------------------
// reed_muller_generator_rows
// Row source for the generator matrix of the Reed-Muller code RM(r,m):
// one row per request, with its index, degree and a last-row flag.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_ready, req_restart       | in
//  rsp     | rsp_valid, rsp_ready, rsp_row_bits,     | out
//          | rsp_row_index, rsp_row_degree,          |
//          | rsp_last_row                            |
//  csr     | csr_we, csr_index, csr_wdata            | in (write only)
//
// Sequence: one request at a time. A request passes from acceptance to the
//   next acceptance through accept, prep, the row AND unit (one slot per
//   cycle, then the done check), the next-combination scan (one slot per
//   cycle) and the output load.
// Reset: synchronous, active high; code_order = 1, variable_count = 4,
//   enumeration back at row 0. No clearing pass.
// Stalls: the finished row sits in the output register; a new request is
//   taken while it waits, and the next row is held back until it drains.
// ----------------------------------------------------------------------------
module reed_muller_generator_rows #(
   parameter int MAX_VARS  = 6,
   parameter int ROW_WIDTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_restart,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ROW_WIDTH-1:0]               rsp_row_bits,
   output logic [rmgr_pkg::INDEX_W-1:0]       rsp_row_index,
   output logic [rmgr_pkg::DEG_W-1:0]         rsp_row_degree,
   output logic                               rsp_last_row,
   // configuration write port
   input  logic                               csr_we,
   input  logic [rmgr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rmgr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rmgr_pkg::cmd_type    cmd;
   rmgr_pkg::status_type st;

   // sequencer: request/result handshakes and step commands
   rmgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // enumeration state, row accumulator, config and output payload
   rmgr_datapath #(
      .MAX_VARS  (MAX_VARS),
      .ROW_WIDTH (ROW_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_restart    (req_restart),
      .cmd            (cmd),
      .st             (st),
      .rsp_row_bits   (rsp_row_bits),
      .rsp_row_index  (rsp_row_index),
      .rsp_row_degree (rsp_row_degree),
      .rsp_last_row   (rsp_last_row)
   );

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // a taken request keeps the block busy for at least the next cycle
   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request port ready right after taking a request");

   // degree never exceeds the variable limit
   a_degree_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_degree <= rmgr_pkg::DEG_W'(MAX_VARS)))
      else $error("row degree above variable limit");

   // degree 0 only ever appears as row 0
   a_degree0_row0 : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_row_degree == '0)) |-> (rsp_row_index == '0))
      else $error("degree-0 row with nonzero index");

   // the output register is loaded only from the result step, never while idle
   a_load_from_out : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!cmd.row_step && !cmd.scan_step && !req_ready))
      else $error("output load outside the result step");

endmodule

>>> tb/rm_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_row_checker
// Watches the request, row and register ports of the Reed-Muller row source.
// It keeps its own copy of the enumeration state, works out each expected row
// when a request is taken, and compares every delivered row field by field.
// ----------------------------------------------------------------------------
module rm_row_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_restart,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [63:0]                       rsp_row_bits,
   input  logic [rmgr_pkg::INDEX_W-1:0]      rsp_row_index,
   input  logic [rmgr_pkg::DEG_W-1:0]        rsp_row_degree,
   input  logic                              rsp_last_row,
   input  logic                              csr_we,
   input  logic [rmgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rmgr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                mismatches,
   output int                                in_flight
);

   localparam int MAX_VARS = 6;

   typedef struct packed {
      logic [63:0]                  bits;
      logic [rmgr_pkg::INDEX_W-1:0] index;
      logic [rmgr_pkg::DEG_W-1:0]   degree;
      logic                         last;
   } gen_row_type;

   logic [rmgr_pkg::CSR_DATA_W-1:0] order_reg;
   logic [rmgr_pkg::CSR_DATA_W-1:0] vars_reg;
   logic [rmgr_pkg::DEG_W-1:0]      deg_next;
   logic [rmgr_pkg::SLOT_W-1:0]     slot_next [MAX_VARS];
   logic [rmgr_pkg::CNT_W-1:0]      row_count;
   logic                            matrix_done;

   gen_row_type rows_due [$];

   // Row for the request just taken; steps the enumeration forward.
   function automatic gen_row_type next_generator_row(input logic restart);
      int          m, r, d, p, q, k;
      logic [63:0] cols, acc, var_bits;
      logic        last;
      gen_row_type row;
      m = int'(vars_reg);
      if (m > MAX_VARS) m = MAX_VARS;
      r = int'(order_reg);
      if (r > m) r = m;
      if (restart) begin
         deg_next = '0;
         row_count = '0;
         matrix_done = 1'b0;
      end
      d = int'(deg_next);
      if (matrix_done) last = 1'b1;
      else if (d < r) last = 1'b0;
      else if (d == 0) last = 1'b1;
      else last = int'(slot_next[0]) >= m - d + 1;

      cols = (m == MAX_VARS) ? '1 : (64'd1 << (1 << m)) - 64'd1;
      acc = '1;
      for (p = 0; p < d && p < MAX_VARS; p++) begin
         var_bits = '0;
         if (slot_next[p] >= 1 && int'(slot_next[p]) <= m)
            for (k = 0; k < 64; k++)
               var_bits[k] = ((k >> (m - int'(slot_next[p]))) & 1) != 0;
         acc &= var_bits;
      end
      row.bits = acc & cols;
      row.index = row_count[rmgr_pkg::INDEX_W-1:0];
      row.degree = deg_next;
      row.last = last;

      if (last) begin
         matrix_done = 1'b1;
      end else begin
         if (d == 0) begin
            deg_next = rmgr_pkg::DEG_W'(1);
            slot_next[0] = rmgr_pkg::SLOT_W'(1);
         end else begin
            // rightmost slot that can still move up
            p = d - 1;
            while (p >= 0 && int'(slot_next[p]) >= m - d + 1 + p) p--;
            if (p >= 0) begin
               slot_next[p] = slot_next[p] + 1'b1;
               for (q = p + 1; q < d && q < MAX_VARS; q++)
                  slot_next[q] = slot_next[q-1] + 1'b1;
            end else begin
               if (d < MAX_VARS) d++;
               deg_next = d[rmgr_pkg::DEG_W-1:0];
               for (q = 0; q < d; q++) slot_next[q] = rmgr_pkg::SLOT_W'(q + 1);
            end
         end
         if (row_count != 7'd127) row_count = row_count + 1'b1;
      end
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns mismatch: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      gen_row_type want;
      if (reset) begin
         order_reg = rmgr_pkg::CODE_ORDER_RST;
         vars_reg = rmgr_pkg::VARIABLE_COUNT_RST;
         deg_next = '0;
         for (int i = 0; i < MAX_VARS; i++) slot_next[i] = '0;
         row_count = '0;
         matrix_done = 1'b0;
         rows_due.delete();
         mismatches = 0;
         in_flight <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rmgr_pkg::CSR_CODE_ORDER:     order_reg = csr_wdata;
               rmgr_pkg::CSR_VARIABLE_COUNT: vars_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (rows_due.size() == 0) begin
               report_mismatch("row with no request pending", rsp_row_bits, '0);
            end else begin
               want = rows_due.pop_front();
               if (rsp_row_bits !== want.bits)
                  report_mismatch("row_bits", rsp_row_bits, want.bits);
               if (rsp_row_index !== want.index)
                  report_mismatch("row_index", 64'(rsp_row_index), 64'(want.index));
               if (rsp_row_degree !== want.degree)
                  report_mismatch("row_degree", 64'(rsp_row_degree), 64'(want.degree));
               if (rsp_last_row !== want.last)
                  report_mismatch("last_row", 64'(rsp_last_row), 64'(want.last));
            end
         end
         if (req_valid && req_ready)
            rows_due.push_back(next_generator_row(req_restart));
         in_flight <= rows_due.size();
      end
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the Reed-Muller generator row source with row requests and register
// writes: a directed walk through default, degenerate and clamped settings,
// then random phases of mostly full matrix walks under random back-pressure.
// The checker beside the block predicts and compares every row.
// ----------------------------------------------------------------------------
module tb;

   localparam int REQ_TARGET  = 1050;   // requests in the whole run
   localparam int CALM_AFTER  = 950;    // no idling on either side after this
   localparam int DRAIN_TAIL  = 20;     // outlasts the slowest request

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_restart = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [63:0]                     rsp_row_bits;
   logic [rmgr_pkg::INDEX_W-1:0]    rsp_row_index;
   logic [rmgr_pkg::DEG_W-1:0]      rsp_row_degree;
   logic                            rsp_last_row;
   logic                            csr_we = 1'b0;
   logic [rmgr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rmgr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches;
   int in_flight;
   int sent = 0;
   bit calm = 1'b0;
   int stall_left = 0;

   always #1 clock = ~clock;

   reed_muller_generator_rows u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_bits   (rsp_row_bits),
      .rsp_row_index  (rsp_row_index),
      .rsp_row_degree (rsp_row_degree),
      .rsp_last_row   (rsp_last_row),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   rm_row_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_bits   (rsp_row_bits),
      .rsp_row_index  (rsp_row_index),
      .rsp_row_degree (rsp_row_degree),
      .rsp_last_row   (rsp_last_row),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .in_flight      (in_flight)
   );

   // Row sink back-pressure: random runs of ready and of stall, each of random
   // length; always ready once the run goes calm.
   always @(posedge clock) begin
      bit stall;
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall = $urandom_range(0, 2) == 0;
         rsp_ready <= !stall;
         stall_left <= stall ? $urandom_range(0, 13) : $urandom_range(0, 39);
      end
   end

   // One row request. An optional idle burst goes first; valid then stays up
   // until the block takes the request. Valid is left high on return so the
   // next request can follow back to back.
   task automatic send_request(input logic restart);
      int gap;
      gap = (calm || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (sent >= CALM_AFTER) calm = 1'b1;
   endtask

   // Drop valid, wait for every row in flight to come out, then give the
   // block time to finish its next-combination scan before any register write.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rmgr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rmgr_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int kind, len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // Default RM(1,4): first request after reset has no restart and must
      // still give row 0. Rows 0..4, then the last row repeats with the flag.
      repeat (7) send_request(1'b0);
      send_request(1'b1);
      settle();

      // Zero variables and order zero: the whole matrix is a single 1.
      write_csr(rmgr_pkg::CSR_CODE_ORDER, 3'd0);
      write_csr(rmgr_pkg::CSR_VARIABLE_COUNT, 3'd0);
      send_request(1'b1);
      repeat (2) send_request(1'b0);
      settle();

      // Both registers at the top of the field: clamped to RM(6,6). Stop part
      // way into the degree-2 rows.
      write_csr(rmgr_pkg::CSR_CODE_ORDER, 3'd7);
      write_csr(rmgr_pkg::CSR_VARIABLE_COUNT, 3'd7);
      send_request(1'b1);
      repeat (9) send_request(1'b0);
      settle();

      // Shrink the setup mid-matrix without a restart: the held combination
      // names a variable that no longer exists, giving an all-zero row.
      write_csr(rmgr_pkg::CSR_VARIABLE_COUNT, 3'd3);
      write_csr(rmgr_pkg::CSR_CODE_ORDER, 3'd2);
      repeat (3) send_request(1'b0);
      settle();

      // --- random part ---
      while (sent < REQ_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind != 0)
            write_csr(rmgr_pkg::CSR_CODE_ORDER,
                      rmgr_pkg::CSR_DATA_W'($urandom_range(0, 7)));
         if (kind != 1)
            write_csr(rmgr_pkg::CSR_VARIABLE_COUNT,
                      rmgr_pkg::CSR_DATA_W'($urandom_range(0, 7)));
         if ($urandom_range(0, 9) < 8) begin
            // well-formed walk: restart, then a random number of rows, possibly past the end
            send_request(1'b1);
            len = $urandom_range(0, 70);
            repeat (len) send_request(1'b0);
         end else begin
            // noise: restarts at random points, possibly none at the start
            len = $urandom_range(1, 30);
            repeat (len) send_request($urandom_range(0, 3) == 0);
         end
         settle();
      end

      if (mismatches == 0 && in_flight == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog: ends the run with FAIL if it has not finished.
   initial begin
      #1000000;
      $display("FAIL");
      $finish;
   end

endmodule
